// File: sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/bdba_pkg.sv
// Constants and types for the bitmap disk block allocator.
// No dependencies; imported by bitmap_disk_block_allocator.
package bdba_pkg;

  localparam int MAP_BYTES         = 8;
  localparam int BITS_PER_BYTE     = 8;
  localparam int SECTORS_PER_TRACK = 4;
  localparam int FILE_SLOTS        = 16;
  localparam int NUM_BLOCKS        = MAP_BYTES * BITS_PER_BYTE;
  localparam int RESULT_LIMIT      = 64;

  localparam int BLK_W    = $clog2(NUM_BLOCKS);
  localparam int BIT_W    = $clog2(BITS_PER_BYTE);
  localparam int SEC_W    = $clog2(SECTORS_PER_TRACK);
  localparam int FID_W    = $clog2(FILE_SLOTS);
  localparam int CNT_W    = $clog2(RESULT_LIMIT + 1);
  localparam int STATUS_W = 3;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_GRANT      = 3'd0;
  localparam status_t ST_FREED      = 3'd1;
  localparam status_t ST_ALLOC_FAIL = 3'd2;
  localparam status_t ST_UNKNOWN    = 3'd3;
  localparam status_t ST_IN_USE     = 3'd4;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RECYCLE = 1'b1;

endpackage

// File: sv/bitmap_disk_block_allocator.sv
// Bitmap disk block allocator: a rejected request gives its one result in the cycle after accept;
// otherwise the bitmap is scanned from block 0, one block per cycle unless the output stalls,
// and the request holds the allocator until the scan has reached its last block.
// No new item until the last result is out or leaving.
// Reset (synchronous) frees every block, clears the file table and sets the free count to 64.
// Depends on bdba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bitmap_disk_block_allocator
  import bdba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 operation,
  input  logic [FID_W-1:0]     file_id,
  input  logic [CNT_W-1:0]     block_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [BLK_W-1:0]     block_index,
  output logic [BLK_W-BIT_W-1:0] cylinder,
  output logic [BIT_W-SEC_W-1:0] track,
  output logic [SEC_W-1:0]     sector,
  output logic                 last
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state;
  logic [NUM_BLOCKS-1:0] used;
  logic [FID_W-1:0]      owner_mem [NUM_BLOCKS];
  logic [FID_W-1:0]      owner_q;
  logic [FILE_SLOTS-1:0] active;
  logic [CNT_W-1:0]      file_len [FILE_SLOTS];
  logic [CNT_W-1:0]      free_blocks;
  logic                  op_q;
  logic [FID_W-1:0]      fid_q;
  logic [CNT_W-1:0]      remain;
  logic [BLK_W-1:0]      idx;

  logic             out_free;
  logic             in_accept;
  logic             step;
  logic             hit;
  logic             finish;
  logic [BLK_W-1:0] rd_addr;
  logic             req_fail;
  status_t          fail_status;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign step      = (state == S_SCAN) && out_free;
  assign hit       = (op_q == OP_RECYCLE) ? (used[idx] && owner_q == fid_q) : !used[idx];
  assign finish    = step && hit && (remain == CNT_W'(1));

  // owner_q tracks owner_mem[idx] during the scan; idle points it at block 0
  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = '0;
    end else if (step && !finish) begin
      rd_addr = idx + BLK_W'(1);
    end else begin
      rd_addr = idx;
    end
  end

  always_comb begin
    req_fail    = 1'b0;
    fail_status = ST_ALLOC_FAIL;
    if (operation == OP_ALLOC) begin
      if (block_count == '0) begin
        req_fail = 1'b1;
      end else if (active[file_id]) begin
        req_fail    = 1'b1;
        fail_status = ST_IN_USE;
      end else if (block_count > CNT_W'(RESULT_LIMIT) || block_count > free_blocks) begin
        req_fail = 1'b1;
      end
    end else if (!active[file_id]) begin
      req_fail    = 1'b1;
      fail_status = ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hit && op_q == OP_ALLOC) begin
      owner_mem[idx] <= fid_q;
    end
    owner_q <= owner_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_accept && !req_fail && operation == OP_ALLOC) begin
      file_len[file_id] <= block_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      used        <= '0;
      active      <= '0;
      free_blocks <= CNT_W'(NUM_BLOCKS);
      out_valid   <= 1'b0;
    end else begin
      if ((in_accept && req_fail) || (step && hit)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        op_q  <= operation;
        fid_q <= file_id;
        idx   <= '0;
        if (req_fail) begin
          status      <= fail_status;
          block_index <= '0;
          cylinder    <= '0;
          track       <= '0;
          sector      <= '0;
          last        <= 1'b1;
        end else begin
          state <= S_SCAN;
          if (operation == OP_ALLOC) begin
            remain          <= block_count;
            active[file_id] <= 1'b1;
          end else begin
            remain          <= file_len[file_id];
            active[file_id] <= 1'b0;
          end
        end
      end else if (step) begin
        if (hit) begin
          block_index <= idx;
          cylinder    <= idx[BLK_W-1:BIT_W];
          track       <= idx[BIT_W-1:SEC_W];
          sector      <= idx[SEC_W-1:0];
          last        <= finish;
          remain      <= remain - CNT_W'(1);
          if (op_q == OP_ALLOC) begin
            status      <= ST_GRANT;
            used[idx]   <= 1'b1;
            free_blocks <= free_blocks - CNT_W'(1);
          end else begin
            status      <= ST_FREED;
            used[idx]   <= 1'b0;
            free_blocks <= free_blocks + CNT_W'(1);
          end
        end
        if (finish) begin
          state <= S_IDLE;
        end else begin
          idx <= idx + BLK_W'(1);
        end
      end
    end
  end

  `ASSERT_ALWAYS(free_count_matches_map, clk, rst, free_blocks == NUM_BLOCKS - $countones(used))
  `ASSERT_IMPLIES(scan_has_work_left, clk, rst, state == S_SCAN, remain != '0)
  `ASSERT_IMPLIES(scan_ends_by_last_block, clk, rst, step && idx == BLK_W'(NUM_BLOCKS - 1), finish)
  `ASSERT_IMPLIES(reject_is_single_item, clk, rst, out_valid && (status == ST_ALLOC_FAIL || status == ST_UNKNOWN || status == ST_IN_USE), last && block_index == '0)

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for bitmap_disk_block_allocator: predicts every block report
// of each request from a mirror of the bitmap, owner tags and file table.
// Depends on bdba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_top;
  import bdba_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 160;
  localparam int CYL_W        = BLK_W - BIT_W;
  localparam int TRK_W        = BIT_W - SEC_W;

  typedef struct packed {
    status_t                  status;
    logic [BLK_W-1:0]         block_index;
    logic [CYL_W-1:0]         cylinder;
    logic [TRK_W-1:0]         track;
    logic [SEC_W-1:0]         sector;
    logic                     last;
  } block_report_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_BURST} stall_mode_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    operation = OP_ALLOC;
  logic [FID_W-1:0]        file_id = '0;
  logic [CNT_W-1:0]        block_count = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic [BLK_W-1:0]        block_index;
  logic [CYL_W-1:0]        cylinder;
  logic [TRK_W-1:0]        track;
  logic [SEC_W-1:0]        sector;
  logic                    last;

  // mirror of the allocator state
  logic             disk_used  [NUM_BLOCKS];
  logic [FID_W-1:0] disk_owner [NUM_BLOCKS];
  logic             slot_active[FILE_SLOTS];
  int               free_count;

  block_report_t expected_results[$];

  int mismatch_count  = 0;
  int requests_sent   = 0;
  int allocs_sent     = 0;
  int recycles_sent   = 0;
  int rejects_seen    = 0;
  int reports_checked = 0;
  int cycle_count     = 0;
  int burst_left      = 0;

  stall_mode_t stall_mode;
  int          stall_span;
  logic [7:0]  stall_phase;

  bitmap_disk_block_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .file_id(file_id), .block_count(block_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .block_index(block_index), .cylinder(cylinder),
    .track(track), .sector(sector), .last(last)
  );

  always #5 clk = ~clk;

  function automatic block_report_t make_report(status_t st, int blk, logic is_last);
    block_report_t r;
    int bit_in_byte;
    bit_in_byte   = blk % BITS_PER_BYTE;
    r.status      = st;
    r.block_index = BLK_W'(blk);
    r.cylinder    = CYL_W'(blk / BITS_PER_BYTE);
    r.track       = TRK_W'(bit_in_byte / SECTORS_PER_TRACK);
    r.sector      = SEC_W'(bit_in_byte % SECTORS_PER_TRACK);
    r.last        = is_last;
    return r;
  endfunction

  // Update the mirror for one accepted request and queue the reports it causes.
  task automatic predict_request(input logic op, input logic [FID_W-1:0] fid,
                                 input logic [CNT_W-1:0] cnt);
    block_report_t batch[$];
    int n;
    n = 0;
    if (op == OP_ALLOC) begin
      // zero count is tested before the in-use check
      if (cnt == 0 || fid >= FILE_SLOTS) begin
        batch = {batch, make_report(ST_ALLOC_FAIL, 0, 1'b1)};
      end else if (slot_active[fid]) begin
        batch = {batch, make_report(ST_IN_USE, 0, 1'b1)};
      end else if (cnt > RESULT_LIMIT || cnt > free_count) begin
        batch = {batch, make_report(ST_ALLOC_FAIL, 0, 1'b1)};
      end else begin
        for (int b = 0; b < NUM_BLOCKS && n < cnt; b++) begin
          if (!disk_used[b]) begin
            disk_used[b]  = 1'b1;
            disk_owner[b] = fid;
            batch = {batch, make_report(ST_GRANT, b, (n + 1 == cnt))};
            n++;
          end
        end
        free_count -= cnt;
        slot_active[fid] = 1'b1;
      end
    end else begin
      if (fid >= FILE_SLOTS || !slot_active[fid]) begin
        batch = {batch, make_report(ST_UNKNOWN, 0, 1'b1)};
      end else begin
        for (int b = 0; b < NUM_BLOCKS && n < RESULT_LIMIT; b++) begin
          if (disk_used[b] && disk_owner[b] == fid) begin
            disk_used[b] = 1'b0;
            free_count++;
            batch = {batch, make_report(ST_FREED, b, 1'b0)};
            n++;
          end
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        slot_active[fid] = 1'b0;
      end
    end
    if (batch.size() == 1 && batch[0].status != ST_GRANT && batch[0].status != ST_FREED)
      rejects_seen++;
    expected_results = {expected_results, batch};
  endtask

  // Sender: bursts of random length separated by random gaps.
  task automatic send_item(input logic op, input int fid, input int cnt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    operation   <= op;
    file_id     <= FID_W'(fid);
    block_count <= CNT_W'(cnt);
    do @(posedge clk); while (in_stall);
    predict_request(op, FID_W'(fid), CNT_W'(cnt));
    requests_sent++;
    if (op == OP_ALLOC) allocs_sent++;
    else recycles_sent++;
  endtask

  // Random slot that is active (want_active) or idle; -1 when there is none.
  function automatic int pick_slot(logic want_active);
    int pool[$];
    for (int s = 0; s < FILE_SLOTS; s++)
      if (slot_active[s] == want_active) pool = {pool, s};
    if (pool.size() == 0) return -1;
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  task automatic test_edge_cases();
    send_item(OP_ALLOC,   4'd0,  7'd0);    // zero count on a free disk
    send_item(OP_RECYCLE, 4'd5,  7'd0);    // unknown file
    send_item(OP_ALLOC,   4'd1,  7'd65);   // just past the result limit
    send_item(OP_ALLOC,   4'd1,  7'd127);
    send_item(OP_ALLOC,   4'd0,  7'd1);    // block 0
    send_item(OP_ALLOC,   4'd0,  7'd3);    // file in use
    send_item(OP_ALLOC,   4'd0,  7'd0);    // zero count wins over in use
    send_item(OP_ALLOC,   4'd15, 7'd5);
    send_item(OP_ALLOC,   4'd7,  7'd59);   // one more than free
    send_item(OP_ALLOC,   4'd7,  7'd58);   // fills the disk exactly
    send_item(OP_ALLOC,   4'd3,  7'd1);    // disk full
    send_item(OP_RECYCLE, 4'd15, 7'd127);  // count ignored on recycle
    send_item(OP_ALLOC,   4'd3,  7'd2);    // first fit lands in the hole
    send_item(OP_RECYCLE, 4'd0,  7'd0);
    send_item(OP_RECYCLE, 4'd0,  7'd0);    // already recycled
    send_item(OP_RECYCLE, 4'd7,  7'd64);
    send_item(OP_RECYCLE, 4'd3,  7'd0);
    send_item(OP_ALLOC,   4'd9,  7'd64);   // whole disk in one request
    send_item(OP_RECYCLE, 4'd9,  7'd0);
    send_item(OP_RECYCLE, 4'd9,  7'd127);
    send_item(OP_ALLOC,   4'd10, 7'd2);
    send_item(OP_ALLOC,   4'd12, 7'd63);   // too few: 62 left
    send_item(OP_RECYCLE, 4'd10, 7'd85);
  endtask

  // Fill the disk with a few large files, overflow it, then free everything.
  task automatic test_full_disk();
    int slot;
    int chunk;
    slot = pick_slot(1'b0);
    while (free_count > 0 && slot >= 0) begin
      chunk = $urandom_range(1, free_count);
      send_item(OP_ALLOC, slot, chunk);
      slot = pick_slot(1'b0);
    end
    slot = pick_slot(1'b0);
    if (slot >= 0) send_item(OP_ALLOC, slot, $urandom_range(1, 64));
    slot = pick_slot(1'b1);
    while (slot >= 0) begin
      send_item(OP_RECYCLE, slot, $urandom);
      slot = pick_slot(1'b1);
    end
  endtask

  // Mostly well-formed allocate/recycle traffic with small counts, plus noise.
  task automatic test_random_mix(input int n_items);
    int r;
    int act;
    int idle;
    int cap;
    for (int i = 0; i < n_items; i++) begin
      r    = $urandom_range(0, 99);
      act  = pick_slot(1'b1);
      idle = pick_slot(1'b0);
      if (r < 50 && idle >= 0 && free_count > 0) begin
        cap = (free_count < 8) ? free_count : 8;
        if ($urandom_range(0, 9) == 0) cap = free_count;
        send_item(OP_ALLOC, idle, $urandom_range(1, cap));
      end else if (r < 82 && act >= 0) begin
        send_item(OP_RECYCLE, act, $urandom);
      end else begin
        case ($urandom_range(0, 4))
          0: send_item(OP_ALLOC, $urandom_range(0, 15), 7'd0);
          1: send_item(OP_ALLOC, $urandom_range(0, 15), $urandom_range(65, 127));
          2: send_item(OP_ALLOC, $urandom_range(0, 15), $urandom_range(1, 127));
          3: send_item(OP_RECYCLE, $urandom_range(0, 15), $urandom);
          default: begin
            if (free_count < RESULT_LIMIT && idle >= 0)
              send_item(OP_ALLOC, idle, $urandom_range(free_count + 1, RESULT_LIMIT));
            else
              send_item(OP_ALLOC, $urandom_range(0, 15), $urandom);
          end
        endcase
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver stall pattern: switches between modes after a random span.
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      stall_mode  = STALL_NONE;
      stall_span  = 0;
      stall_phase = '0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_span = $urandom_range(20, 300);
      end
      stall_span--;
      stall_phase++;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: out_stall <= (stall_phase[1:0] != 2'd0);
        default:        out_stall <= (stall_phase[4:3] == 2'd0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    block_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected item: status %0d block %0d last %0d", status, block_index, last);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        reports_checked++;
        check_field("status",      want.status,      status);
        check_field("block_index", want.block_index, block_index);
        check_field("cylinder",    want.cylinder,    cylinder);
        check_field("track",       want.track,       track);
        check_field("sector",      want.sector,      sector);
        check_field("last",        want.last,        last);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d reports outstanding",
           cycle_count, expected_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      disk_used[b]  = 1'b0;
      disk_owner[b] = '0;
    end
    for (int s = 0; s < FILE_SLOTS; s++) slot_active[s] = 1'b0;
    free_count = NUM_BLOCKS;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_cases();
    test_full_disk();
    test_random_mix(270);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d allocate, %0d recycle), %0d rejected;",
             requests_sent, allocs_sent, recycles_sent, rejects_seen);
    $display("checked %0d block reports in %0d cycles.", reports_checked, cycle_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/bdba_pkg.sv
sv/bitmap_disk_block_allocator.sv
tb/sv/tb_top.sv
